>>> sv/ede_pkg.sv
// ----------------------------------------------------------------------------
// ede_pkg
// Shared types and constants for the edit distance engine.
// ----------------------------------------------------------------------------
package ede_pkg;

    localparam int CHAR_W   = 8;
    localparam int DIST_W   = 7;
    localparam int DIST_SAT = 127;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_SOURCE = 2'd2,
        ACT_FINISH = 2'd3
    } t_action;

    typedef enum logic {
        ST_IDLE,
        ST_WAIT
    } t_state;

    typedef struct packed {
        logic              vld;
        logic [CHAR_W-1:0] ch;
    } t_wave;

endpackage

>>> sv/ede_if.sv
// ----------------------------------------------------------------------------
// ede_in_if / ede_out_if
// Valid/ready channels for input items and distance results.
// ----------------------------------------------------------------------------
interface ede_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] character;

    modport source (output valid, output action, output character, input ready);
    modport sink   (input valid, input action, input character, output ready);
endinterface

interface ede_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] distance;
    logic       overflow;

    modport source (output valid, output distance, output overflow, input ready);
    modport sink   (input valid, input distance, input overflow, output ready);
endinterface

>>> sv/ede_cell.sv
// ----------------------------------------------------------------------------
// ede_cell
// One column of the DP row: holds a target byte and its row entry, updates
// the entry as a source wave passes and hands the wave to the next cell.
// ----------------------------------------------------------------------------
module ede_cell
    import ede_pkg::*;
#(
    parameter int IDX = 0,
    parameter int LW  = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_clear,
    input  logic              i_load_en,
    input  logic [LW-1:0]     i_load_idx,
    input  logic [CHAR_W-1:0] i_load_ch,
    input  t_wave             i_wave,
    input  logic [LW-1:0]     i_left,
    input  logic [LW-1:0]     i_diag,
    output t_wave             o_wave,
    output logic [LW-1:0]     o_left,
    output logic [LW-1:0]     o_diag
);

    logic              r_tvld;
    logic [CHAR_W-1:0] r_tch;
    logic [LW-1:0]     r_up;
    logic              r_wave_vld;
    logic [CHAR_W-1:0] r_wave_ch;
    logic [LW-1:0]     r_left;
    logic [LW-1:0]     r_diag;

    logic [LW:0]       a_sum;
    logic [LW:0]       b_sum;
    logic [LW:0]       c_sum;
    logic [LW:0]       m_ab;
    logic [LW:0]       m_all;
    logic [LW-1:0]     n_val;

    always_comb begin
        a_sum = {1'b0, i_left} + {{LW{1'b0}}, 1'b1};
        b_sum = {1'b0, r_up} + {{LW{1'b0}}, 1'b1};
        c_sum = {1'b0, i_diag} + {{LW{1'b0}}, (r_tch != i_wave.ch)};
        m_ab  = (a_sum < b_sum) ? a_sum : b_sum;
        m_all = (m_ab < c_sum) ? m_ab : c_sum;
        n_val = m_all[LW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_tvld     <= 1'b0;
            r_up       <= LW'(IDX + 1);
            r_wave_vld <= 1'b0;
        end else begin
            r_wave_vld <= i_wave.vld;
            if (i_load_en && (i_load_idx == LW'(IDX))) begin
                r_tvld <= 1'b1;
            end
            if (i_wave.vld && r_tvld) begin
                r_up <= n_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load_en && (i_load_idx == LW'(IDX))) begin
            r_tch <= i_load_ch;
        end
        r_wave_ch <= i_wave.ch;
        r_left    <= r_tvld ? n_val : i_left;
        r_diag    <= r_up;
    end

    assign o_wave.vld = r_wave_vld;
    assign o_wave.ch  = r_wave_ch;
    assign o_left     = r_left;
    assign o_diag     = r_diag;

endmodule

>>> sv/edit_distance_engine.sv
// ----------------------------------------------------------------------------
// edit_distance_engine
// Levenshtein distance between a target and a source byte string, computed
// by a chain of DP cells swept by one wavefront per source byte.
//
//   channel   dir  fields                     beat
//   i_in      in   action[1:0], character[7:0] one action
//   o_out     out  distance[6:0], overflow     one result per finish
//
// Clear, append and source beats may follow back to back, each source wave
// moving one cell per cycle down the chain. A finish waits for the last
// source wave to leave the chain, then loads the output register.
// Reset (synchronous, active low) gives an empty pair with no overflow.
// Input is stalled from a finish beat until its result is loaded, which
// also waits for the previous result to be taken.
// ----------------------------------------------------------------------------
module edit_distance_engine
    import ede_pkg::*;
#(
    parameter int MAX_LEN = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ede_in_if.sink    i_in,
    ede_out_if.source o_out
);

    localparam int LW = $clog2(MAX_LEN + 1);

    t_state            r_state;
    t_state            n_state;
    logic [LW-1:0]     r_tlen;
    logic [LW-1:0]     n_tlen;
    logic [LW-1:0]     r_slen;
    logic [LW-1:0]     n_slen;
    logic              r_ovf;
    logic              n_ovf;
    logic [LW-1:0]     r_result;
    logic [LW-1:0]     n_result;
    logic [LW-1:0]     r_drain;
    logic [LW-1:0]     n_drain;
    logic              r_out_vld;
    logic              n_out_vld;
    logic [DIST_W-1:0] r_out_dist;
    logic              r_out_ovf;

    logic              accept;
    t_action           act;
    logic              clear;
    logic              load_en;
    logic              launch;
    logic              out_load;
    logic [DIST_W-1:0] sat_dist;

    t_wave             wave  [MAX_LEN+1];
    logic [LW-1:0]     left  [MAX_LEN+1];
    logic [LW-1:0]     diag  [MAX_LEN+1];

    assign i_in.ready = (r_state == ST_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign act        = t_action'(i_in.action);

    assign sat_dist = (32'(r_result) > 32'(DIST_SAT)) ? DIST_W'(DIST_SAT)
                                                      : DIST_W'(r_result);

    always_comb begin
        n_state   = r_state;
        n_tlen    = r_tlen;
        n_slen    = r_slen;
        n_ovf     = r_ovf;
        n_result  = r_result;
        n_drain   = r_drain;
        clear     = 1'b0;
        load_en   = 1'b0;
        launch    = 1'b0;
        out_load  = 1'b0;
        n_out_vld = r_out_vld && !o_out.ready;

        if (r_drain != '0) begin
            n_drain = r_drain - LW'(1);
        end
        if (wave[MAX_LEN].vld) begin
            n_result = left[MAX_LEN];
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (act)
                        ACT_CLEAR: begin
                            clear    = 1'b1;
                            n_tlen   = '0;
                            n_slen   = '0;
                            n_ovf    = 1'b0;
                            n_result = '0;
                            n_drain  = '0;
                        end
                        ACT_APPEND: begin
                            if (r_slen == '0) begin
                                if (r_tlen == LW'(MAX_LEN)) begin
                                    n_ovf = 1'b1;
                                end else begin
                                    load_en  = 1'b1;
                                    n_tlen   = r_tlen + LW'(1);
                                    n_result = r_tlen + LW'(1);
                                end
                            end
                        end
                        ACT_SOURCE: begin
                            if (r_slen == LW'(MAX_LEN)) begin
                                n_ovf = 1'b1;
                            end else begin
                                launch  = 1'b1;
                                n_slen  = r_slen + LW'(1);
                                n_drain = LW'(MAX_LEN);
                            end
                        end
                        ACT_FINISH: begin
                            n_state = ST_WAIT;
                        end
                        default: begin
                            n_state = r_state;
                        end
                    endcase
                end
            end
            ST_WAIT: begin
                if ((r_drain == '0) && (!r_out_vld || o_out.ready)) begin
                    out_load  = 1'b1;
                    n_out_vld = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_tlen    <= '0;
            r_slen    <= '0;
            r_ovf     <= 1'b0;
            r_result  <= '0;
            r_drain   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_tlen    <= n_tlen;
            r_slen    <= n_slen;
            r_ovf     <= n_ovf;
            r_result  <= n_result;
            r_drain   <= n_drain;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_dist <= sat_dist;
            r_out_ovf  <= r_ovf;
        end
    end

    assign wave[0].vld = launch;
    assign wave[0].ch  = i_in.character;
    assign left[0]     = r_slen + LW'(1);
    assign diag[0]     = r_slen;

    for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
        ede_cell #(
            .IDX (j),
            .LW  (LW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_clear    (clear),
            .i_load_en  (load_en),
            .i_load_idx (r_tlen),
            .i_load_ch  (i_in.character),
            .i_wave     (wave[j]),
            .i_left     (left[j]),
            .i_diag     (diag[j]),
            .o_wave     (wave[j+1]),
            .o_left     (left[j+1]),
            .o_diag     (diag[j+1])
        );
    end

    assign o_out.valid    = r_out_vld;
    assign o_out.distance = r_out_dist;
    assign o_out.overflow = r_out_ovf;

endmodule

>>> bench/edit_distance_checker.sv
// ----------------------------------------------------------------------------
// edit_distance_checker
// Watches the input and result channels of the edit distance engine, keeps
// its own copy of the DP row and target string, and predicts the distance
// and overflow flag for every finish beat. Results are compared in order
// against the predictions, and mismatches are counted for the testbench top.
// ----------------------------------------------------------------------------
module edit_distance_checker
    import ede_pkg::*;
#(
    parameter int MAX_LEN = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ede_in_if    i_in_ch,
    ede_out_if   i_out_ch,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int ROW_W = $clog2(MAX_LEN + 2) + 1;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              overflow;
    } t_result;

    logic [CHAR_W-1:0] target_bytes [MAX_LEN];
    logic [ROW_W-1:0]  cost_row [MAX_LEN+1];
    int unsigned       target_len;
    int unsigned       source_len;
    logic              sticky_ovf;
    t_result           expected_q [$];
    int                fails = 0;

    task automatic clear_pair();
        for (int i = 0; i <= MAX_LEN; i++) begin
            cost_row[i] = ROW_W'(i);
        end
        target_len = 0;
        source_len = 0;
        sticky_ovf = 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_result           want;
        logic [ROW_W-1:0]  diag;
        logic [ROW_W-1:0]  up;
        logic [ROW_W-1:0]  best;
        logic [CHAR_W-1:0] ch;
        if (!i_rst_n) begin
            clear_pair();
            expected_q.delete();
        end else begin
            if (i_out_ch.valid === 1'b1 && i_out_ch.ready === 1'b1) begin
                if (expected_q.size() == 0) begin
                    if (fails < 10) begin
                        $display("unexpected result beat: distance %0d overflow %0b",
                                 i_out_ch.distance, i_out_ch.overflow);
                    end
                    fails++;
                end else begin
                    want = expected_q.pop_front();
                    if (i_out_ch.distance !== want.distance ||
                        i_out_ch.overflow !== want.overflow) begin
                        if (fails < 10) begin
                            $display("mismatch: exp dist %0d ovf %0b, got dist %0d ovf %0b",
                                     want.distance, want.overflow,
                                     i_out_ch.distance, i_out_ch.overflow);
                        end
                        fails++;
                    end
                end
            end
            if (i_in_ch.valid === 1'b1 && i_in_ch.ready === 1'b1) begin
                ch = i_in_ch.character;
                case (t_action'(i_in_ch.action))
                    ACT_CLEAR: begin
                        clear_pair();
                    end
                    ACT_APPEND: begin
                        // drop target bytes once the source has started
                        if (source_len == 0) begin
                            if (target_len >= MAX_LEN) begin
                                sticky_ovf = 1'b1;
                            end else begin
                                target_bytes[target_len] = ch;
                                target_len++;
                            end
                        end
                    end
                    ACT_SOURCE: begin
                        if (source_len >= MAX_LEN) begin
                            sticky_ovf = 1'b1;
                        end else begin
                            diag        = cost_row[0];
                            cost_row[0] = ROW_W'(source_len + 1);
                            for (int j = 1; j <= target_len; j++) begin
                                up   = cost_row[j];
                                best = diag + ROW_W'(target_bytes[j-1] != ch);
                                if (up + 1 < best) begin
                                    best = up + 1;
                                end
                                if (cost_row[j-1] + 1 < best) begin
                                    best = cost_row[j-1] + 1;
                                end
                                cost_row[j] = best;
                                diag        = up;
                            end
                            source_len++;
                        end
                    end
                    ACT_FINISH: begin
                        if (cost_row[target_len] > DIST_SAT) begin
                            want.distance = DIST_W'(DIST_SAT);
                        end else begin
                            want.distance = DIST_W'(cost_row[target_len]);
                        end
                        want.overflow = sticky_ovf;
                        expected_q.push_back(want);
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_q.size();
    end

endmodule

>>> bench/tb_edit_distance_engine.sv
// ----------------------------------------------------------------------------
// tb_edit_distance_engine
// Drives clear, append, source and finish beats into the edit distance
// engine: a short directed set of corner cases, then random string pairs
// of mostly small and a few maximal lengths, with noise and broken pairs.
// The sender runs in random bursts, the receiver stalls on its own pattern
// and once holds off long enough to back up the input. Prediction and
// comparison live in edit_distance_checker.
// ----------------------------------------------------------------------------
module tb_edit_distance_engine;
    import ede_pkg::*;

    localparam int MAX_LEN     = 64;
    localparam int ITEM_TARGET = 1150;
    localparam int DRAIN       = MAX_LEN + 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 500;

    typedef enum int {
        RX_OPEN,
        RX_MOSTLY,
        RX_SPARSE,
        RX_TOGGLE
    } t_rx_mode;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    int       fail_count;
    int       pending;
    int       items_sent = 0;
    int       burst_left = 0;
    int       cycle_count = 0;
    bit       random_phase = 1'b0;
    bit       hold_off = 1'b0;
    t_rx_mode rx_mode = RX_OPEN;
    int       rx_left = 0;
    bit       rx_go = 1'b0;

    ede_in_if  in_ch ();
    ede_out_if out_ch ();

    edit_distance_engine #(
        .MAX_LEN (MAX_LEN)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    edit_distance_checker #(
        .MAX_LEN (MAX_LEN)
    ) u_distance_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("edit_distance_engine verification failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 96);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:   rx_go = 1'b1;
            RX_MOSTLY: rx_go = ($urandom_range(0, 3) != 0);
            RX_SPARSE: rx_go = ($urandom_range(0, 3) == 0);
            default:   rx_go = ~rx_go;
        endcase
        out_ch.ready <= rx_go && !hold_off;
    end

    // hold the result side off while the sender keeps offering beats
    initial begin
        wait (random_phase);
        repeat (30) @(posedge i_clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off = 1'b0;
    end

    function automatic logic [CHAR_W-1:0] pick_byte(input bit narrow);
        if (narrow) begin
            return 8'h61 + CHAR_W'($urandom_range(0, 3));
        end
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    task automatic send_item(input t_action act, input logic [CHAR_W-1:0] ch);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 10);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                in_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        @(negedge i_clk);
        in_ch.valid     <= 1'b1;
        in_ch.action    <= act;
        in_ch.character <= ch;
        do @(posedge i_clk); while (!(in_ch.valid === 1'b1 && in_ch.ready === 1'b1));
        burst_left--;
        items_sent++;
    endtask

    initial begin
        int                tlen;
        int                slen;
        int                kind;
        int                pair_idx;
        bit                narrow;
        logic [CHAR_W-1:0] b;
        logic [CHAR_W-1:0] tgt [$];
        in_ch.valid     <= 1'b0;
        in_ch.action    <= ACT_CLEAR;
        in_ch.character <= '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // both strings empty straight out of reset
        send_item(ACT_FINISH, 8'h00);
        send_item(ACT_APPEND, 8'h00);
        send_item(ACT_APPEND, 8'hFF);
        send_item(ACT_APPEND, 8'h5A);
        // empty source
        send_item(ACT_FINISH, 8'hFF);
        send_item(ACT_SOURCE, 8'hFF);
        // target byte after source is dropped
        send_item(ACT_APPEND, 8'h11);
        send_item(ACT_SOURCE, 8'h00);
        send_item(ACT_FINISH, 8'h00);
        send_item(ACT_FINISH, 8'hFF);
        // continue the pair after finish
        send_item(ACT_SOURCE, 8'h5A);
        send_item(ACT_FINISH, 8'h00);
        send_item(ACT_CLEAR, 8'hFF);
        // empty target
        send_item(ACT_SOURCE, 8'hAA);
        send_item(ACT_SOURCE, 8'h55);
        send_item(ACT_FINISH, 8'h00);
        send_item(ACT_CLEAR, 8'h00);
        send_item(ACT_FINISH, 8'h00);

        random_phase = 1'b1;
        pair_idx     = 0;
        while (items_sent < ITEM_TARGET) begin
            narrow = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    send_item(t_action'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)));
                end
            end
            if (pair_idx == 0) begin
                tlen = MAX_LEN + 2;
                slen = $urandom_range(0, 6);
            end else if (pair_idx == 1) begin
                tlen = $urandom_range(1, 12);
                slen = MAX_LEN + 3;
            end else begin
                kind = $urandom_range(0, 99);
                if (kind < 3) begin
                    tlen = $urandom_range(MAX_LEN - 2, MAX_LEN + 3);
                    slen = $urandom_range(MAX_LEN - 2, MAX_LEN + 3);
                end else if (kind < 23) begin
                    tlen = $urandom_range(0, 24);
                    slen = $urandom_range(0, 24);
                end else begin
                    tlen = $urandom_range(0, 8);
                    slen = $urandom_range(0, 8);
                end
            end
            send_item(ACT_CLEAR, CHAR_W'($urandom_range(0, 255)));
            tgt.delete();
            for (int n = 0; n < tlen; n++) begin
                b = pick_byte(narrow);
                tgt.push_back(b);
                send_item(ACT_APPEND, b);
            end
            for (int n = 0; n < slen; n++) begin
                if ($urandom_range(0, 19) == 0) begin
                    send_item(ACT_APPEND, pick_byte(narrow));
                end
                if (n < tgt.size() && $urandom_range(0, 3) != 0) begin
                    b = tgt[n];
                end else begin
                    b = pick_byte(narrow);
                end
                send_item(ACT_SOURCE, b);
            end
            // leave some pairs unfinished
            if ($urandom_range(0, 9) != 0) begin
                send_item(ACT_FINISH, CHAR_W'($urandom_range(0, 255)));
                if ($urandom_range(0, 6) == 0) begin
                    send_item(ACT_FINISH, CHAR_W'($urandom_range(0, 255)));
                end
                if ($urandom_range(0, 6) == 0) begin
                    repeat ($urandom_range(1, 3)) begin
                        send_item(ACT_SOURCE, pick_byte(narrow));
                    end
                    send_item(ACT_FINISH, CHAR_W'($urandom_range(0, 255)));
                end
            end
            pair_idx++;
        end
        send_item(ACT_FINISH, 8'h00);

        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("edit_distance_engine verification clean");
        end else begin
            $display("edit_distance_engine verification failed");
        end
        $finish;
    end

endmodule
